### hw/rtl/rld_pkg.sv
// rld_pkg: shared types and constants of the extent run-list decoder
`timescale 1ns / 1ps

package rld_pkg;

    localparam int CB_W            = 22;  // cluster size register width
    localparam int ACC_BYTES       = 8;   // bytes in a 64-bit accumulator
    localparam int FIELD_BYTES_MAX = 8;   // largest length or offset field

    localparam logic [CB_W-1:0] CLUSTER_BYTES_RESET = 22'd4096;

    // end-of-list status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_TERM  = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;
    localparam logic [1:0] ST_OVERSIZE = 2'd3;

    typedef struct packed {
        logic [7:0] list_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [63:0] byte_offset;
        logic [63:0] byte_length;
        logic [63:0] total_size;
        logic        last_of_run;
    } out_item_t;

    // what one decoded byte asks of the back end
    typedef struct packed {
        logic       add_len;    // a run finished: add its length to the data size
        logic       emit_run;   // the finished run has an offset: show it
        logic       emit_end;   // the list ends here
        logic [1:0] end_status;
    } ev_flags_t;

    typedef struct packed {
        ev_flags_t   flags;
        logic [63:0] len;       // run length in clusters
        logic [63:0] cluster;   // run start cluster
    } ev_t;

    typedef struct packed {
        ev_flags_t   flags;
        logic [63:0] blen;      // run length in bytes
        logic [63:0] boff;      // run start in bytes
    } scaled_t;

endpackage

### hw/rtl/extent_run_list_decoder.sv
// extent_run_list_decoder: streaming run-list decoder, top level
//
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_stall       in_item   (list_byte, final_byte)
//  out       output     out_valid / out_stall     out_item  (kind .. last_of_run)
//  cfg       input      cfg_wr_en                 cfg_wr_data (cluster_bytes)
//
//  one byte transaction is accepted per cycle while in_stall is low; its results pass through
//  the event register, two partial-product stages, the combine stage and the result register
//  a byte that ends a run with an offset and its list makes two result transactions, both
//  held in the result register; a held event register stalls every byte, result or not
//  out_stall ripples back through the pipeline ready chain to in_stall
//  reset clears the list state and running data size; cluster size resets to 4096
`timescale 1ns / 1ps

module extent_run_list_decoder
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [rld_pkg::CB_W-1:0] cfg_wr_data,
    // byte transactions in
    input  logic                     in_valid,
    output logic                     in_stall,
    input  rld_pkg::in_item_t        in_item,
    // result transactions out
    output logic                     out_valid,
    input  logic                     out_stall,
    output rld_pkg::out_item_t       out_item
);

    // bytes per cluster, used as is (zero gives zero offsets and lengths)
    logic [rld_pkg::CB_W-1:0] cluster_bytes_reg;

    // parser to scaler
    logic             ev_valid;
    logic             ev_ready;
    rld_pkg::ev_t     ev;
    // scaler to result stage
    logic             sc_valid;
    logic             sc_ready;
    rld_pkg::scaled_t sc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cluster_bytes_reg <= rld_pkg::CLUSTER_BYTES_RESET;
        else if (cfg_wr_en)
            cluster_bytes_reg <= cfg_wr_data;
    end

    // header and field bytes, sign extension, running cluster number
    rld_decode u_decode
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev       (ev)
    );

    // clusters to bytes, 64 x 22 split into two 32-bit halves over two stages
    rld_scale u_scale
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cluster_bytes (cluster_bytes_reg),
        .ev_valid      (ev_valid),
        .ev_ready      (ev_ready),
        .ev            (ev),
        .sc_valid      (sc_valid),
        .sc_ready      (sc_ready),
        .sc            (sc)
    );

    // running data size, run and end results
    rld_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sc_valid  (sc_valid),
        .sc_ready  (sc_ready),
        .sc        (sc),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

### hw/rtl/rld_decode.sv
// rld_decode: byte parser of the run list with event register, one byte per cycle while not stalled
`timescale 1ns / 1ps

module rld_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rld_pkg::in_item_t in_item,
    output logic              ev_valid,
    input  logic              ev_ready,
    output rld_pkg::ev_t      ev
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_OFFSET = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  length_size_reg, length_size_next;
    logic [3:0]  offset_size_reg, offset_size_next;
    logic [3:0]  byte_count_reg, byte_count_next;
    logic [63:0] length_accum_reg, length_accum_next;
    logic [63:0] offset_accum_reg, offset_accum_next;
    logic [63:0] cluster_reg, cluster_next;

    logic         ev_valid_reg;
    rld_pkg::ev_t ev_reg;
    rld_pkg::ev_t ev_new;

    logic [7:0]  b;
    logic        fin;
    logic [3:0]  ls;
    logic [3:0]  os;
    logic [3:0]  os_eff;
    logic [3:0]  bc_inc;
    logic [63:0] shifted;
    logic [63:0] len_c;
    logic [63:0] off_c;
    logic [63:0] cluster_sum;
    logic        complete;
    logic        in_header;
    logic        clr;
    logic        in_fire;

    assign b        = in_item.list_byte;
    assign fin      = in_item.final_byte;
    assign ls       = b[3:0];
    assign os       = b[7:4];
    assign bc_inc   = byte_count_reg + 4'd1;
    assign shifted  = {56'd0, b} << {byte_count_reg[2:0], 3'b000};
    assign in_stall = ev_valid_reg && !ev_ready;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        phase_next        = phase_reg;
        length_size_next  = length_size_reg;
        offset_size_next  = offset_size_reg;
        byte_count_next   = byte_count_reg;
        length_accum_next = length_accum_reg;
        offset_accum_next = offset_accum_reg;
        cluster_next      = cluster_reg;
        len_c             = length_accum_reg;
        off_c             = offset_accum_reg;
        os_eff            = offset_size_reg;
        complete          = 1'b0;
        in_header         = 1'b0;
        clr               = 1'b0;
        ev_new            = '0;

        case (phase_reg)
            PH_LENGTH:
            begin
                len_c             = length_accum_reg | shifted;
                length_accum_next = len_c;
                byte_count_next   = bc_inc;
                if (bc_inc >= length_size_reg)
                begin
                    byte_count_next = 4'd0;
                    if (offset_size_reg != 4'd0)
                        phase_next = PH_OFFSET;
                    else
                        complete = 1'b1;
                end
            end
            PH_OFFSET:
            begin
                off_c           = offset_accum_reg | shifted;
                byte_count_next = bc_inc;
                if (bc_inc >= offset_size_reg)
                begin
                    // sign extension from the top byte of a short field
                    if (b[7] && (offset_size_reg < 4'(rld_pkg::ACC_BYTES)))
                        off_c = off_c | (~64'd0 << {offset_size_reg[2:0], 3'b000});
                    complete = 1'b1;
                end
                offset_accum_next = off_c;
            end
            default:
            begin
                in_header = 1'b1;
                os_eff    = os;
                if (b == 8'd0)
                begin
                    ev_new.flags.emit_end   = 1'b1;
                    ev_new.flags.end_status = rld_pkg::ST_OK;
                    clr                     = 1'b1;
                end
                else if (fin)
                begin
                    ev_new.flags.emit_end   = 1'b1;
                    ev_new.flags.end_status = rld_pkg::ST_TRUNC;
                    clr                     = 1'b1;
                end
                else if ((ls > 4'(rld_pkg::FIELD_BYTES_MAX))
                         || (os > 4'(rld_pkg::FIELD_BYTES_MAX)))
                begin
                    ev_new.flags.emit_end   = 1'b1;
                    ev_new.flags.end_status = rld_pkg::ST_OVERSIZE;
                    clr                     = 1'b1;
                end
                else
                begin
                    length_size_next  = ls;
                    offset_size_next  = os;
                    byte_count_next   = 4'd0;
                    length_accum_next = 64'd0;
                    offset_accum_next = 64'd0;
                    len_c             = 64'd0;
                    off_c             = 64'd0;
                    if (ls != 4'd0)
                        phase_next = PH_LENGTH;
                    else if (os != 4'd0)
                        phase_next = PH_OFFSET;
                    else
                        complete = 1'b1;
                end
            end
        endcase

        cluster_sum = cluster_reg + off_c;

        if (complete)
        begin
            phase_next          = PH_HEADER;
            byte_count_next     = 4'd0;
            ev_new.flags.add_len = 1'b1;
            ev_new.len          = len_c;
            if (os_eff != 4'd0)
            begin
                cluster_next          = cluster_sum;
                ev_new.flags.emit_run = 1'b1;
                ev_new.cluster        = cluster_sum;
            end
            if (fin)
            begin
                ev_new.flags.emit_end   = 1'b1;
                ev_new.flags.end_status = rld_pkg::ST_NO_TERM;
                clr                     = 1'b1;
            end
        end
        else if (fin && !in_header)
        begin
            // partial run dropped
            ev_new.flags.emit_end   = 1'b1;
            ev_new.flags.end_status = rld_pkg::ST_TRUNC;
            clr                     = 1'b1;
        end

        if (clr)
        begin
            phase_next        = PH_HEADER;
            length_size_next  = 4'd0;
            offset_size_next  = 4'd0;
            byte_count_next   = 4'd0;
            length_accum_next = 64'd0;
            offset_accum_next = 64'd0;
            cluster_next      = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            length_size_reg  <= 4'd0;
            offset_size_reg  <= 4'd0;
            byte_count_reg   <= 4'd0;
            length_accum_reg <= 64'd0;
            offset_accum_reg <= 64'd0;
            cluster_reg      <= 64'd0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            length_size_reg  <= length_size_next;
            offset_size_reg  <= offset_size_next;
            byte_count_reg   <= byte_count_next;
            length_accum_reg <= length_accum_next;
            offset_accum_reg <= offset_accum_next;
            cluster_reg      <= cluster_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_valid_reg <= 1'b0;
        else if (!ev_valid_reg || ev_ready)
            ev_valid_reg <= in_fire && (ev_new.flags.add_len || ev_new.flags.emit_end);
    end

    always_ff @(posedge clk)
    begin
        if (!ev_valid_reg || ev_ready)
            ev_reg <= ev_new;
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

endmodule

### hw/rtl/rld_scale.sv
// rld_scale: pipelined scaling of run length and start cluster by the cluster size
`timescale 1ns / 1ps

module rld_scale
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rld_pkg::CB_W-1:0]  cluster_bytes,
    input  logic                      ev_valid,
    output logic                      ev_ready,
    input  rld_pkg::ev_t              ev,
    output logic                      sc_valid,
    input  logic                      sc_ready,
    output rld_pkg::scaled_t          sc
);

    localparam int PW = 32 + rld_pkg::CB_W;  // low partial product width

    // stage a: low-half products
    logic                 a_valid_reg;
    rld_pkg::ev_flags_t   a_flags_reg;
    logic [31:0]          a_len_hi_reg;
    logic [31:0]          a_cc_hi_reg;
    logic [PW-1:0]        a_len_lo_reg;
    logic [PW-1:0]        a_cc_lo_reg;
    // stage b: high-half products
    logic                 b_valid_reg;
    rld_pkg::ev_flags_t   b_flags_reg;
    logic [PW-1:0]        b_len_lo_reg;
    logic [PW-1:0]        b_cc_lo_reg;
    logic [31:0]          b_len_hi_reg;
    logic [31:0]          b_cc_hi_reg;
    // stage c: combined
    logic                 c_valid_reg;
    rld_pkg::scaled_t     c_reg;

    logic a_ready;
    logic b_ready;
    logic c_ready;
    logic [31:0] cb32;

    assign cb32     = {{(32-rld_pkg::CB_W){1'b0}}, cluster_bytes};
    assign c_ready  = !c_valid_reg || sc_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign ev_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= ev_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_flags_reg  <= ev.flags;
            a_len_hi_reg <= ev.len[63:32];
            a_cc_hi_reg  <= ev.cluster[63:32];
            a_len_lo_reg <= PW'(ev.len[31:0]) * PW'(cluster_bytes);
            a_cc_lo_reg  <= PW'(ev.cluster[31:0]) * PW'(cluster_bytes);
        end
        if (b_ready)
        begin
            b_flags_reg  <= a_flags_reg;
            b_len_lo_reg <= a_len_lo_reg;
            b_cc_lo_reg  <= a_cc_lo_reg;
            // only the low 32 bits survive the shift into a 64-bit result
            b_len_hi_reg <= a_len_hi_reg * cb32;
            b_cc_hi_reg  <= a_cc_hi_reg * cb32;
        end
        if (c_ready)
        begin
            c_reg.flags <= b_flags_reg;
            c_reg.blen  <= {{(64-PW){1'b0}}, b_len_lo_reg} + {b_len_hi_reg, 32'd0};
            c_reg.boff  <= {{(64-PW){1'b0}}, b_cc_lo_reg} + {b_cc_hi_reg, 32'd0};
        end
    end

    assign sc_valid = c_valid_reg;
    assign sc       = c_reg;

endmodule

### hw/rtl/rld_out.sv
// rld_out: running data size and the result register, up to two results per event
`timescale 1ns / 1ps

module rld_out
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sc_valid,
    output logic               sc_ready,
    input  rld_pkg::scaled_t   sc,
    output logic               out_valid,
    input  logic               out_stall,
    output rld_pkg::out_item_t out_item
);

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_END = 1'b1;

    logic        run_pend_reg;
    logic        end_pend_reg;
    logic [63:0] data_size_reg;
    logic [63:0] data_size_next;
    logic [63:0] total_reg;
    logic [63:0] boff_reg;
    logic [63:0] blen_reg;
    logic [1:0]  status_reg;
    logic        out_fire;
    logic        load;

    assign out_valid      = run_pend_reg || end_pend_reg;
    assign out_fire       = out_valid && !out_stall;
    assign sc_ready       = !out_valid || (out_fire && !(run_pend_reg && end_pend_reg));
    assign load           = sc_valid && sc_ready;
    assign data_size_next = data_size_reg + (sc.flags.add_len ? sc.blen : 64'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_pend_reg  <= 1'b0;
            end_pend_reg  <= 1'b0;
            data_size_reg <= 64'd0;
        end
        else if (load)
        begin
            run_pend_reg  <= sc.flags.emit_run;
            end_pend_reg  <= sc.flags.emit_end;
            data_size_reg <= sc.flags.emit_end ? 64'd0 : data_size_next;
        end
        else if (out_fire)
        begin
            if (run_pend_reg && end_pend_reg)
                run_pend_reg <= 1'b0;
            else
            begin
                run_pend_reg <= 1'b0;
                end_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            total_reg  <= data_size_next;
            boff_reg   <= sc.boff;
            blen_reg   <= sc.blen;
            status_reg <= sc.flags.end_status;
        end
    end

    always_comb
    begin
        out_item.total_size = total_reg;
        if (run_pend_reg)
        begin
            out_item.kind        = KIND_RUN;
            out_item.status      = rld_pkg::ST_OK;
            out_item.byte_offset = boff_reg;
            out_item.byte_length = blen_reg;
            out_item.last_of_run = !end_pend_reg;
        end
        else
        begin
            out_item.kind        = KIND_END;
            out_item.status      = status_reg;
            out_item.byte_offset = 64'd0;
            out_item.byte_length = 64'd0;
            out_item.last_of_run = 1'b1;
        end
    end

endmodule

### bench/extent_run_list_decoder_checker.sv
// run-list decoder checker: watches both channels, predicts results and compares them
`timescale 1ns / 1ps

module extent_run_list_decoder_checker
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [rld_pkg::CB_W-1:0] cfg_wr_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  rld_pkg::in_item_t        in_item,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  rld_pkg::out_item_t       out_item,
    output int                       bad_results,
    output int                       results_owed
);
    import rld_pkg::*;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_END = 1'b1;
    localparam int   REPORT_MAX = 10;

    typedef enum logic [1:0] {AWAIT_HEADER, IN_LENGTH, IN_OFFSET} list_phase_e;

    logic [CB_W-1:0] cluster_size;
    list_phase_e     phase;
    logic [3:0]      len_bytes;
    logic [3:0]      off_bytes;
    logic [3:0]      field_idx;
    logic [63:0]     len_acc;
    logic [63:0]     off_acc;
    logic [63:0]     cluster_no;
    logic [63:0]     running_size;

    out_item_t decoded_q[$];
    out_item_t want;

    task automatic clear_list();
        phase        = AWAIT_HEADER;
        len_bytes    = '0;
        off_bytes    = '0;
        field_idx    = '0;
        len_acc      = '0;
        off_acc      = '0;
        cluster_no   = '0;
        running_size = '0;
    endtask

    function automatic out_item_t make_result(input logic kind, input logic [1:0] status,
                                              input logic [63:0] boff,
                                              input logic [63:0] blen);
        out_item_t r;
        r.kind        = kind;
        r.status      = status;
        r.byte_offset = boff;
        r.byte_length = blen;
        r.total_size  = running_size;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // advances the list state by one byte and queues the results it causes
    task automatic decode_list_byte(input logic [7:0] b, input logic fin);
        out_item_t   res [2];
        int          n;
        logic        done;
        logic        closed;
        logic [3:0]  ls;
        logic [3:0]  os;
        logic [63:0] blen;
        n      = 0;
        done   = 1'b0;
        closed = 1'b0;
        ls     = b[3:0];
        os     = b[7:4];
        res[0] = '0;
        res[1] = '0;
        case (phase)
            IN_LENGTH:
            begin
                len_acc   = len_acc | ({56'b0, b} << (8 * field_idx[2:0]));
                field_idx = field_idx + 4'd1;
                if (field_idx >= len_bytes)
                begin
                    field_idx = '0;
                    if (off_bytes != 0)
                        phase = IN_OFFSET;
                    else
                        done = 1'b1;
                end
            end
            IN_OFFSET:
            begin
                off_acc   = off_acc | ({56'b0, b} << (8 * field_idx[2:0]));
                field_idx = field_idx + 4'd1;
                if (field_idx >= off_bytes)
                begin
                    if (b[7] && off_bytes < 8)
                        off_acc = off_acc | (~64'd0 << (8 * off_bytes));
                    done = 1'b1;
                end
            end
            default:
            begin
                if (b == 8'h00)
                begin
                    res[0] = make_result(KIND_END, ST_OK, '0, '0);
                    n = 1;
                    closed = 1'b1;
                end
                else if (fin)
                begin
                    res[0] = make_result(KIND_END, ST_TRUNC, '0, '0);
                    n = 1;
                    closed = 1'b1;
                end
                else if (ls > FIELD_BYTES_MAX || os > FIELD_BYTES_MAX)
                begin
                    res[0] = make_result(KIND_END, ST_OVERSIZE, '0, '0);
                    n = 1;
                    closed = 1'b1;
                end
                else
                begin
                    len_bytes = ls;
                    off_bytes = os;
                    field_idx = '0;
                    len_acc   = '0;
                    off_acc   = '0;
                    // a nonzero header with a zero length nibble has an offset
                    phase     = (ls != 0) ? IN_LENGTH : IN_OFFSET;
                end
            end
        endcase

        if (closed)
            clear_list();
        else if (done)
        begin
            blen         = len_acc * {42'b0, cluster_size};
            phase        = AWAIT_HEADER;
            field_idx    = '0;
            running_size = running_size + blen;
            // sparse runs only grow the data size
            if (off_bytes != 0)
            begin
                cluster_no = cluster_no + off_acc;
                res[n] = make_result(KIND_RUN, ST_OK, cluster_no * {42'b0, cluster_size}, blen);
                n++;
            end
            if (fin)
            begin
                res[n] = make_result(KIND_END, ST_NO_TERM, '0, '0);
                n++;
                clear_list();
            end
        end
        else if (fin)
        begin
            res[n] = make_result(KIND_END, ST_TRUNC, '0, '0);
            n++;
            clear_list();
        end

        if (n > 0)
            res[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            decoded_q.push_back(res[i]);
    endtask

    task automatic note_bad(input string what, input out_item_t exp, input out_item_t act);
        bad_results++;
        if (bad_results <= REPORT_MAX)
        begin
            $display("%0t rld %s: exp kind %0d st %0d off %h len %h tot %h last %0d",
                     $time, what, exp.kind, exp.status, exp.byte_offset,
                     exp.byte_length, exp.total_size, exp.last_of_run);
            $display("%0t rld %s: got kind %0d st %0d off %h len %h tot %h last %0d",
                     $time, what, act.kind, act.status, act.byte_offset,
                     act.byte_length, act.total_size, act.last_of_run);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_size = CLUSTER_BYTES_RESET;
            clear_list();
            decoded_q.delete();
            bad_results = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                    note_bad("result with none owed", '0, out_item);
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_item.kind !== want.kind || out_item.status !== want.status ||
                        out_item.byte_offset !== want.byte_offset ||
                        out_item.byte_length !== want.byte_length ||
                        out_item.total_size !== want.total_size ||
                        out_item.last_of_run !== want.last_of_run)
                        note_bad("mismatch", want, out_item);
                end
            end
            if (in_valid && !in_stall)
                decode_list_byte(in_item.list_byte, in_item.final_byte);
            if (cfg_wr_en)
                cluster_size = cfg_wr_data;
        end
        results_owed = decoded_q.size();
    end

endmodule

### bench/extent_run_list_decoder_tb.sv
// run-list decoder testbench top: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module extent_run_list_decoder_tb;
    import rld_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;    // long receiver hold-off, fills the pipeline
    localparam int SETTLE_CYCLES   = 20;     // wait after the last owed result, before a write or the verdict
    localparam int PHASE_BYTES     = 170;    // random byte transactions per cluster setting

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [CB_W-1:0] cfg_wr_data;
    logic            in_valid;
    logic            in_stall;
    in_item_t        in_item;
    logic            out_valid;
    logic            out_stall;
    out_item_t       out_item;

    int bad_results;
    int results_owed;
    int bytes_sent;
    int burst_left;
    int hold_requests;
    int hold_served;

    extent_run_list_decoder dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    extent_run_list_decoder_checker u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item),
        .bad_results  (bad_results),
        .results_owed (results_owed)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard ceiling on run time, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("[extent_run_list_decoder] ERROR");
        $finish;
    end

    // receiver: stall pattern changes at random intervals; a hold-off request
    // from the stimulus side keeps out_stall high for a long stretch
    initial
    begin : receiver
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    0:       out_stall <= 1'b0;                          // free-flowing
                    1:       out_stall <= ($urandom_range(0, 99) < 20);  // light stalls
                    2:       out_stall <= ($urandom_range(0, 99) < 70);  // heavy stalls
                    default: out_stall <= ~out_stall;                    // alternating
                endcase
            end
        end
    end

    // offer one byte transaction and hold it until accepted; bursts of random
    // length separated by random gaps, with the odd long burst
    task automatic send_byte(input logic [7:0] b, input logic fin);
        in_item_t item;
        int       gap;
        item.list_byte  = b;
        item.final_byte = fin;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 30);
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // one list, mostly well formed; the rest truncated, oversize or plain noise
    task automatic send_list();
        int pick;
        int ending;
        int runs;
        int ls;
        int os;
        int cut;
        int need;
        logic last_run;
        pick = $urandom_range(0, 99);
        if (pick < 78)
        begin
            runs   = $urandom_range(1, 5);
            ending = $urandom_range(0, 99);   // <65 terminator, <85 final on run, else open
            for (int r = 0; r < runs; r++)
            begin
                ls = $urandom_range(0, 8);
                os = $urandom_range(0, 8);
                if (ls == 0 && os == 0)
                    ls = 1;
                last_run = (r == runs - 1) && (ending >= 65) && (ending < 85);
                send_byte({os[3:0], ls[3:0]}, 1'b0);
                for (int i = 0; i < ls; i++)
                    send_byte(8'($urandom_range(0, 255)),
                              last_run && os == 0 && i == ls - 1);
                for (int i = 0; i < os; i++)
                    send_byte(8'($urandom_range(0, 255)), last_run && i == os - 1);
            end
            if (ending < 65)
                send_byte(8'h00, 1'($urandom_range(0, 1)));
        end
        else if (pick < 86)
        begin
            // final flag lands before the run is complete
            ls   = $urandom_range(0, 8);
            os   = $urandom_range(0, 8);
            if (ls == 0 && os == 0)
                os = 1;
            need = ls + os;
            cut  = $urandom_range(0, need - 1);
            send_byte({os[3:0], ls[3:0]}, cut == 0);
            for (int i = 0; i < cut; i++)
                send_byte(8'($urandom_range(0, 255)), i == cut - 1);
        end
        else if (pick < 93)
        begin
            // a size nibble beyond eight bytes, in either position
            ls = $urandom_range(0, 15);
            os = $urandom_range(9, 15);
            if ($urandom_range(0, 1))
                send_byte({os[3:0], ls[3:0]}, $urandom_range(0, 3) == 0);
            else
                send_byte({ls[3:0], os[3:0]}, $urandom_range(0, 3) == 0);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
        end
    endtask

    // the cluster size only changes once the pipeline has emptied
    task automatic set_cluster_bytes(input logic [CB_W-1:0] value);
        go_idle();
        wait (results_owed == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
            send_list();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = CLUSTER_BYTES_RESET;
        in_valid      = 1'b0;
        in_item       = '0;
        bytes_sent    = 0;
        burst_left    = 0;
        hold_requests = 0;
        hold_served   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed lists at the reset cluster size
        send_byte(8'h00, 1'b0);                 // bare terminator
        send_byte(8'h11, 1'b0);                 // run: length 5, offset -128
        send_byte(8'h05, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);                 // sparse run of 3 clusters
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b0);                 // eight-byte offset, no sign extension
        send_byte(8'hFF, 1'b0);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);                 // run completes on the final byte
        send_byte(8'h91, 1'b0);                 // oversize offset nibble
        send_byte(8'h21, 1'b0);                 // final inside a run
        send_byte(8'h07, 1'b1);
        send_byte(8'h31, 1'b1);                 // nonzero header flagged final
        send_byte(8'h00, 1'b1);                 // terminator flagged final
        send_byte(8'h0F, 1'b0);                 // oversize length nibble
        run_random(PHASE_BYTES);

        set_cluster_bytes(22'd1);
        run_random(PHASE_BYTES);

        // largest cluster size in this bench, with the long receiver hold-off
        set_cluster_bytes(22'd2097152);
        hold_requests++;
        run_random(PHASE_BYTES);

        set_cluster_bytes(CB_W'($urandom_range(1, 2097152)));
        run_random(PHASE_BYTES);

        set_cluster_bytes(CLUSTER_BYTES_RESET);
        run_random(PHASE_BYTES);

        // drain, then let the pipeline settle before the verdict
        go_idle();
        wait (results_owed == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bad_results == 0 && results_owed == 0)
            $display("[extent_run_list_decoder] OK");
        else
            $display("[extent_run_list_decoder] ERROR");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rld_pkg.sv
hw/rtl/rld_decode.sv
hw/rtl/rld_scale.sv
hw/rtl/rld_out.sv
hw/rtl/extent_run_list_decoder.sv
bench/extent_run_list_decoder_checker.sv
bench/extent_run_list_decoder_tb.sv
